// ===== hw/rtl/four_button_autorepeat_assert.svh =====
// Assertion helpers for the autorepeat RTL
`ifndef FOUR_BUTTON_AUTOREPEAT_ASSERT_SVH
`define FOUR_BUTTON_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication
`define FBA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FBA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fba_pkg.sv =====
`timescale 1ns / 1ps

package fba_pkg;

  localparam int unsigned CfgWidth   = 24;
  localparam int unsigned TimerWidth = 34;

  typedef enum logic {
    ACT_EVENT = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  typedef enum logic {
    REG_INITIAL_DELAY   = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } reg_index_t;

  localparam logic [CfgWidth-1:0] InitialDelayReset   = 24'd500000;
  localparam logic [CfgWidth-1:0] RepeatIntervalReset = 24'd100000;

  localparam logic [TimerWidth-1:0] TimerMax = {1'b0, {(TimerWidth-1){1'b1}}};

  typedef struct packed {
    logic        action;
    logic [1:0]  direction;
    logic        pressed;
    logic [19:0] elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic up_held;
    logic down_held;
    logic left_held;
    logic right_held;
  } out_word_t;

  // bit 0 up .. bit 3 right
  typedef struct packed {
    logic [3:0]            levels;
    logic [3:0]            reported;
    logic [TimerWidth-1:0] timer;
  } fba_state_t;

endpackage

// ===== hw/rtl/fba_step.sv =====
`timescale 1ns / 1ps

module fba_step (
  input  fba_pkg::fba_state_t          state,
  input  fba_pkg::in_word_t            word,
  input  logic [fba_pkg::CfgWidth-1:0] initial_delay,
  input  logic [fba_pkg::CfgWidth-1:0] repeat_interval,
  output fba_pkg::fba_state_t          state_next,
  output logic                         send
);

  localparam int unsigned TW = fba_pkg::TimerWidth;
  localparam int unsigned CW = fba_pkg::CfgWidth;

  logic [TW:0]   sum;
  logic [TW-1:0] acc;
  logic [TW-1:0] delay_ext;
  logic [TW-1:0] sub;
  logic          any_held;
  logic          reach;
  logic          over;
  logic [3:0]    bit_mask;

  assign delay_ext = {{(TW-CW){1'b0}}, initial_delay};
  assign sum = {state.timer[TW-1], state.timer} + {{(TW+1-20){1'b0}}, word.elapsed_us};
  // saturate at the top of the signed range
  assign acc = (!sum[TW] && sum[TW-1]) ? fba_pkg::TimerMax : sum[TW-1:0];
  assign reach = $signed(acc) >= $signed(delay_ext);
  assign sub = acc - {{(TW-CW){1'b0}}, repeat_interval};
  assign over = $signed(sub) > $signed(delay_ext);
  assign any_held = state.levels != 4'b0000;
  assign bit_mask = 4'b0001 << word.direction;

  always_comb begin
    state_next = state;
    send = 1'b0;
    if (word.action == fba_pkg::ACT_EVENT) begin
      if (word.pressed) begin
        state_next.levels = state.levels | bit_mask;
      end else begin
        state_next.levels = state.levels & ~bit_mask;
      end
    end else begin
      state_next.timer = acc;
      if (state.levels != state.reported) begin
        state_next.reported = state.levels;
        state_next.timer = '0;
        send = 1'b1;
      end else if (any_held && reach) begin
        send = 1'b1;
        state_next.timer = over ? '0 : sub;
      end
      if (!any_held) begin
        state_next.timer = '0;
      end
    end
  end

endmodule

// ===== hw/rtl/four_button_autorepeat.sv =====
`timescale 1ns / 1ps
// A word is registered in the input slot at acceptance; its report, if any, is
// loaded into the result register when the slot advances.
// Throughput: one word per cycle; a pending report under stall holds the input slot.
// Reset (synchronous, active high): levels, reported levels and hold timer clear,
// delay 500000 us, interval 100000 us, both channels empty.

`include "four_button_autorepeat_assert.svh"

module four_button_autorepeat (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  fba_pkg::in_word_t            item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output fba_pkg::out_word_t           result,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [fba_pkg::CfgWidth-1:0] cfg_data
);

  logic                         slot_valid;
  fba_pkg::in_word_t            slot_word;
  fba_pkg::fba_state_t          state;
  fba_pkg::fba_state_t          state_next;
  logic [fba_pkg::CfgWidth-1:0] initial_delay;
  logic [fba_pkg::CfgWidth-1:0] repeat_interval;
  logic                         send;
  logic                         advance;
  logic                         accept;
  logic                         load;
  fba_pkg::out_word_t           reported_word;
  logic                         idle_tick;

  fba_step u_step (
    .state           (state),
    .word            (slot_word),
    .initial_delay   (initial_delay),
    .repeat_interval (repeat_interval),
    .state_next      (state_next),
    .send            (send)
  );

  assign advance    = slot_valid && (!send || !result_valid || !result_stall);
  assign load       = advance && send;
  assign item_stall = slot_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= 1'b0;
      result_valid    <= 1'b0;
      state           <= '0;
      initial_delay   <= fba_pkg::InitialDelayReset;
      repeat_interval <= fba_pkg::RepeatIntervalReset;
    end else begin
      if (accept) begin
        slot_valid <= 1'b1;
      end else if (advance) begin
        slot_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (fba_pkg::reg_index_t'(cfg_index))
          fba_pkg::REG_INITIAL_DELAY:   initial_delay   <= cfg_data;
          fba_pkg::REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_word <= item;
    end
    if (load) begin
      result <= {state.levels[0], state.levels[1], state.levels[2], state.levels[3]};
    end
  end

  assign reported_word = {state.reported[0], state.reported[1],
                          state.reported[2], state.reported[3]};
  assign idle_tick     = advance && slot_word.action == fba_pkg::ACT_TICK &&
                         state.levels == 4'b0000;

  `FBA_ASSERT_NOW(a_no_overwrite, result_valid && result_stall, !load, "stalled word overwritten")
  `FBA_ASSERT_NEXT(a_reported_sync, load, state.reported == state.levels, "reported not updated")
  `FBA_ASSERT_NOW(a_out_matches, result_valid, result == reported_word, "result differs")
  `FBA_ASSERT_NEXT(a_idle_timer, idle_tick, state.timer == '0, "timer not cleared when idle")

endmodule
